// ----- src/sia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, codes and sizes of the signed integer ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int WIDTH    = 64;
    localparam int LOG_W    = $clog2(WIDTH);
    localparam int MUL_HALF = (WIDTH + 1) / 2;
    // power unit: two stages per exponent bit plus an output register
    localparam int POW_LAT  = 2 * LOG_W + 1;

    typedef logic [WIDTH-1:0] word_t;

    localparam word_t SIGN_BIT = word_t'(1) << (WIDTH - 1);

    typedef enum logic [4:0] {
        CMD_POS = 5'd0,
        CMD_NEG = 5'd1,
        CMD_NOT = 5'd2,
        CMD_POW = 5'd3,
        CMD_MUL = 5'd4,
        CMD_DIV = 5'd5,
        CMD_MOD = 5'd6,
        CMD_ADD = 5'd7,
        CMD_SUB = 5'd8,
        CMD_SHL = 5'd9,
        CMD_SHR = 5'd10,
        CMD_LT  = 5'd11,
        CMD_LE  = 5'd12,
        CMD_GT  = 5'd13,
        CMD_GE  = 5'd14,
        CMD_EQ  = 5'd15,
        CMD_NE  = 5'd16,
        CMD_AND = 5'd17,
        CMD_XOR = 5'd18,
        CMD_OR  = 5'd19
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DIV0   = 3'd1,
        ST_ZNEG   = 3'd2,
        ST_OVF    = 3'd3,
        ST_BADCMD = 3'd4
    } status_t;

    // per-transaction information carried alongside the arithmetic units
    typedef struct packed {
        logic [4:0] cmd;
        word_t      value;
        status_t    status;
        logic       is_bool;
        logic       neg_q;
        logic       neg_r;
        logic       pow_gen;
        logic       negres;
    } side_t;

endpackage

// ----- src/sia_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_mul
// Two-stage unsigned multiplier: partial products of half words, then sum.
// Gives the low word of the product and a flag for a nonzero high part.
// ----------------------------------------------------------------------------
module sia_mul (
    input  logic          clk,
    input  logic          en,
    input  sia_pkg::word_t x,
    input  sia_pkg::word_t y,
    output sia_pkg::word_t lo,
    output logic          hi_nz
);
    import sia_pkg::*;

    localparam int H = MUL_HALF;

    logic [2*H-1:0] xe, ye;
    logic [2*H-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [4*H-1:0] full;
    word_t          lo_reg;
    logic           hi_reg;

    assign xe = (2*H)'(x);
    assign ye = (2*H)'(y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= (2*H)'(xe[H-1:0])   * (2*H)'(ye[H-1:0]);
            pp_lh_reg <= (2*H)'(xe[H-1:0])   * (2*H)'(ye[2*H-1:H]);
            pp_hl_reg <= (2*H)'(xe[2*H-1:H]) * (2*H)'(ye[H-1:0]);
            pp_hh_reg <= (2*H)'(xe[2*H-1:H]) * (2*H)'(ye[2*H-1:H]);
        end
    end

    assign full = {pp_hh_reg, pp_ll_reg}
                + ((4*H)'(pp_lh_reg) << H)
                + ((4*H)'(pp_hl_reg) << H);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= full[WIDTH-1:0];
            hi_reg <= |full[4*H-1:WIDTH];
        end
    end

    assign lo    = lo_reg;
    assign hi_nz = hi_reg;

endmodule

// ----- src/sia_pow.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pow
// Pipelined square-and-multiply power of an unsigned magnitude, one
// exponent bit per step, with sticky overflow tracking.
// ----------------------------------------------------------------------------
module sia_pow (
    input  logic                    clk,
    input  logic                    en,
    input  sia_pkg::word_t          base,
    input  logic [sia_pkg::LOG_W-1:0] expo,
    output sia_pkg::word_t          mag,
    output logic                    ovf
);
    import sia_pkg::*;

    typedef struct packed {
        word_t            r;
        word_t            b;
        logic [LOG_W-1:0] e;
        logic             rovf;
        logic             bovf;
    } pow_step_t;

    pow_step_t step_in [0:LOG_W];
    pow_step_t s1_reg  [0:LOG_W-1];
    pow_step_t s2_reg  [0:LOG_W-1];
    word_t     r_lo    [0:LOG_W-1];
    word_t     b_lo    [0:LOG_W-1];
    logic      r_hi    [0:LOG_W-1];
    logic      b_hi    [0:LOG_W-1];
    word_t     mag_reg;
    logic      ovf_reg;

    assign step_in[0] = '{r: word_t'(1), b: base, e: expo, rovf: 1'b0, bovf: 1'b0};

    for (genvar k = 0; k < LOG_W; k++)
    begin : g_step
        sia_mul u_mul_r (
            .clk   (clk),
            .en    (en),
            .x     (step_in[k].r),
            .y     (step_in[k].b),
            .lo    (r_lo[k]),
            .hi_nz (r_hi[k])
        );

        sia_mul u_mul_b (
            .clk   (clk),
            .en    (en),
            .x     (step_in[k].b),
            .y     (step_in[k].b),
            .lo    (b_lo[k]),
            .hi_nz (b_hi[k])
        );

        // hold the step state beside the two multiplier stages
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_reg[k] <= step_in[k];
                s2_reg[k] <= s1_reg[k];
            end
        end

        always_comb
        begin
            step_in[k+1]      = s2_reg[k];
            step_in[k+1].b    = b_lo[k];
            step_in[k+1].bovf = s2_reg[k].bovf | b_hi[k];
            if (s2_reg[k].e[k])
            begin
                step_in[k+1].r    = r_lo[k];
                step_in[k+1].rovf = s2_reg[k].rovf | s2_reg[k].bovf | r_hi[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= step_in[LOG_W].r;
            ovf_reg <= step_in[LOG_W].rovf;
        end
    end

    assign mag = mag_reg;
    assign ovf = ovf_reg;

endmodule

// ----- src/sia_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_div
// Pipelined restoring divider of unsigned magnitudes, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module sia_div (
    input  logic           clk,
    input  logic           en,
    input  sia_pkg::word_t num,
    input  sia_pkg::word_t den,
    output sia_pkg::word_t quo,
    output sia_pkg::word_t rem
);
    import sia_pkg::*;

    word_t rem_reg [0:WIDTH-1];
    word_t quo_reg [0:WIDTH-1];
    word_t den_reg [0:WIDTH-1];
    word_t rem_next [0:WIDTH-1];
    word_t quo_next [0:WIDTH-1];

    always_comb
    begin
        logic [WIDTH:0] trial;
        word_t          rp, qp, dp;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (i == 0)
            begin
                rp = '0;
                qp = num;
                dp = den;
            end
            else
            begin
                rp = rem_reg[i-1];
                qp = quo_reg[i-1];
                dp = den_reg[i-1];
            end
            trial = {rp, qp[WIDTH-1]};
            if (trial >= {1'b0, dp})
            begin
                rem_next[i] = WIDTH'(trial - {1'b0, dp});
                quo_next[i] = {qp[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[WIDTH-1:0];
                quo_next[i] = {qp[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[WIDTH-1];
    assign rem = rem_reg[WIDTH-1];

endmodule

// ----- src/signed_integer_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_alu_unit
// Streaming signed integer ALU with pipelined divide and power.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while not stalled and returns each result
// in order. The pipeline depth is set by the divider, which resolves one
// quotient bit per stage; the multiplier and the square-and-multiply power
// unit are shorter and are delayed to match.
// The whole pipeline advances while the output register is empty or being
// taken, so a stalled result holds everything behind it without loss.
// ----------------------------------------------------------------------------
module signed_integer_alu_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // operand_a[63:0], operand_b[127:64]
    input  logic [4:0]   s_axis_tuser,   // command[4:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // result_value[63:0]
    output logic [3:0]   m_axis_tuser    // is_boolean[0], status[3:1]
);
    import sia_pkg::*;

    localparam int MUL_DLY = WIDTH - 2;
    localparam int POW_DLY = WIDTH - POW_LAT;

    logic              adv;
    word_t             a, b, na, nb;
    logic signed [WIDTH-1:0] sa, sb;
    logic              a_neg, b_neg, b_small;
    logic [LOG_W-1:0]  amt;
    side_t             dec;

    logic              valid_reg [0:WIDTH-1];
    side_t             side_reg  [0:WIDTH-1];

    word_t             div_q, div_r, mul_lo, pow_mag;
    logic              mul_hi, pow_ovf;
    word_t             mul_dly [0:MUL_DLY];
    word_t             pow_dly [0:POW_DLY];
    logic              ovf_dly [0:POW_DLY];

    side_t             sd;
    word_t             fin_val, lim;
    status_t           fin_st;
    logic              fin_bool;

    logic              out_valid_reg;
    word_t             out_val_reg;
    status_t           out_st_reg;
    logic              out_bool_reg;
    logic signed [WIDTH-1:0] out_signed;

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- decode and simple operations ----------------
    assign a       = s_axis_tdata[WIDTH-1:0];
    assign b       = s_axis_tdata[64+WIDTH-1:64];
    assign sa      = a;
    assign sb      = b;
    assign a_neg   = a[WIDTH-1];
    assign b_neg   = b[WIDTH-1];
    assign na      = a_neg ? word_t'(-a) : a;
    assign nb      = b_neg ? word_t'(-b) : b;
    assign b_small = !b_neg && (b < word_t'(WIDTH));
    assign amt     = b[LOG_W-1:0];

    always_comb
    begin
        dec         = '0;
        dec.cmd     = s_axis_tuser;
        dec.status  = ST_OK;
        dec.neg_q   = a_neg ^ b_neg;
        dec.neg_r   = a_neg;
        dec.negres  = a_neg & b[0];
        unique case (s_axis_tuser) inside
            CMD_POS: dec.value = a;
            CMD_NEG: dec.value = word_t'(-a);
            CMD_NOT: dec.value = ~a;
            CMD_POW:
            begin
                if (b == '0)
                    dec.value = word_t'(1);
                else if (a == '0)
                begin
                    if (b_neg)
                        dec.status = ST_ZNEG;
                end
                else if (a == word_t'(1))
                    dec.value = word_t'(1);
                else if (a == '1)
                    dec.value = b[0] ? '1 : word_t'(1);
                else if (b_neg)
                    dec.value = '0;
                else if (!b_small)
                    dec.status = ST_OVF;
                else
                    dec.pow_gen = 1'b1;
            end
            CMD_MUL: dec.value = '0;
            CMD_DIV, CMD_MOD:
            begin
                if (b == '0)
                    dec.status = ST_DIV0;
            end
            CMD_ADD: dec.value = a + b;
            CMD_SUB: dec.value = a - b;
            CMD_SHL: dec.value = b_small ? (a << amt) : '0;
            CMD_SHR: dec.value = b_small ? word_t'(sa >>> amt) : {WIDTH{a_neg}};
            CMD_LT:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(sa < sb);
            end
            CMD_LE:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(sa <= sb);
            end
            CMD_GT:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(sa > sb);
            end
            CMD_GE:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(sa >= sb);
            end
            CMD_EQ:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(a == b);
            end
            CMD_NE:
            begin
                dec.is_bool = 1'b1;
                dec.value   = word_t'(a != b);
            end
            CMD_AND: dec.value = a & b;
            CMD_XOR: dec.value = a ^ b;
            CMD_OR:  dec.value = a | b;
            default: dec.status = ST_BADCMD;
        endcase
        if (dec.status != ST_OK)
        begin
            dec.value   = '0;
            dec.is_bool = 1'b0;
            dec.pow_gen = 1'b0;
        end
    end

    // ---------------- transaction side line ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIDTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < WIDTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= dec;
            for (int i = 1; i < WIDTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- arithmetic units ----------------
    sia_div u_div (
        .clk (clk),
        .en  (adv),
        .num (na),
        .den (nb),
        .quo (div_q),
        .rem (div_r)
    );

    sia_mul u_mul (
        .clk   (clk),
        .en    (adv),
        .x     (a),
        .y     (b),
        .lo    (mul_lo),
        .hi_nz (mul_hi)
    );

    sia_pow u_pow (
        .clk  (clk),
        .en   (adv),
        .base (na),
        .expo (b[LOG_W-1:0]),
        .mag  (pow_mag),
        .ovf  (pow_ovf)
    );

    // align the shorter units with the divider output
    assign mul_dly[0] = mul_lo;
    assign pow_dly[0] = pow_mag;
    assign ovf_dly[0] = pow_ovf;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= MUL_DLY; i++)
                mul_dly[i] <= mul_dly[i-1];
            for (int i = 1; i <= POW_DLY; i++)
            begin
                pow_dly[i] <= pow_dly[i-1];
                ovf_dly[i] <= ovf_dly[i-1];
            end
        end
    end

    // ---------------- final select ----------------
    assign sd  = side_reg[WIDTH-1];
    assign lim = sd.negres ? SIGN_BIT : SIGN_BIT - word_t'(1);

    always_comb
    begin
        fin_val  = sd.value;
        fin_st   = sd.status;
        fin_bool = sd.is_bool;
        case (sd.cmd)
            CMD_MUL: fin_val = mul_dly[MUL_DLY];
            CMD_DIV: fin_val = sd.neg_q ? word_t'(-div_q) : div_q;
            CMD_MOD: fin_val = sd.neg_r ? word_t'(-div_r) : div_r;
            CMD_POW:
            begin
                if (sd.pow_gen)
                begin
                    if (ovf_dly[POW_DLY] || (pow_dly[POW_DLY] > lim))
                        fin_st = ST_OVF;
                    fin_val = sd.negres ? word_t'(-pow_dly[POW_DLY]) : pow_dly[POW_DLY];
                end
            end
            default: fin_val = sd.value;
        endcase
        if (fin_st != ST_OK)
        begin
            fin_val  = '0;
            fin_bool = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_val_reg  <= fin_val;
            out_st_reg   <= fin_st;
            out_bool_reg <= fin_bool;
        end
    end

    assign out_signed    = out_val_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 64'(out_signed);
    assign m_axis_tuser  = {out_st_reg, out_bool_reg};

    // the high product word is not part of a wrapped multiply
    logic unused_hi;
    assign unused_hi = mul_hi;

endmodule

// ----- src/sia_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks of the signed integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module sia_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [4:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [3:0]   m_axis_tuser
);
    import sia_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a comparison result is a clean truth value
    a_bool_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tuser[3:1] == ST_OK) && (m_axis_tdata[63:1] == '0))
        else $error("boolean result out of range");

    // an error clears the value and the boolean flag
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] != ST_OK) |->
            (m_axis_tdata == '0) && !m_axis_tuser[0])
        else $error("error result not cleared");

    // status stays within the defined codes
    a_st_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[3:1] <= ST_BADCMD))
        else $error("undefined status code");

endmodule

bind signed_integer_alu_unit sia_checker u_sia_checker (.*);

// ----- tb/alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_checker
// Watches both streams of the ALU, predicts each result and compares it.
// ----------------------------------------------------------------------------
module alu_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [4:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [3:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending
);
    import sia_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        is_bool;
        status_t     status;
    } alu_result_t;

    alu_result_t result_q[$];

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] exact_power(logic [63:0] a, logic [63:0] b,
                                                 inout status_t st);
        logic [63:0] mag, lim, r;
        logic negres;
        r = 64'd1;
        if (b == 0) return 64'd1;
        if (a == 0)
        begin
            if (b[63]) st = ST_ZNEG;
            return 64'd0;
        end
        if (a == 64'd1) return 64'd1;
        if (a == '1) return b[0] ? a : 64'd1;
        if (b[63]) return 64'd0;
        mag = abs64(a);
        negres = a[63] & b[0];
        lim = negres ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (b > 64)
        begin
            st = ST_OVF;
            return 64'd0;
        end
        for (int i = 0; i < b; i++)
        begin
            if (r > lim / mag)
            begin
                st = ST_OVF;
                return 64'd0;
            end
            r = r * mag;
        end
        return negres ? -r : r;
    endfunction

    function automatic alu_result_t compute_alu(logic [4:0] cmd, logic [63:0] a,
                                                logic [63:0] b);
        alu_result_t res;
        logic [63:0] r, q;
        status_t st;
        logic boo;
        r = '0;
        st = ST_OK;
        boo = 1'b0;
        case (cmd) inside
            CMD_POS: r = a;
            CMD_NEG: r = -a;
            CMD_NOT: r = ~a;
            CMD_POW: r = exact_power(a, b, st);
            CMD_MUL: r = a * b;
            CMD_DIV, CMD_MOD:
                if (b == 0) st = ST_DIV0;
                else if (cmd == CMD_DIV)
                begin
                    q = abs64(a) / abs64(b);
                    r = (a[63] != b[63]) ? -q : q;
                end
                else
                begin
                    q = abs64(a) % abs64(b);
                    r = a[63] ? -q : q;
                end
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_SHL: r = (b < 64) ? a << b[5:0] : '0;
            CMD_SHR:
                if (b < 64) r = $signed(a) >>> b[5:0];
                else r = {64{a[63]}};
            CMD_LT:  begin boo = 1'b1; r = 64'($signed(a) <  $signed(b)); end
            CMD_LE:  begin boo = 1'b1; r = 64'($signed(a) <= $signed(b)); end
            CMD_GT:  begin boo = 1'b1; r = 64'($signed(a) >  $signed(b)); end
            CMD_GE:  begin boo = 1'b1; r = 64'($signed(a) >= $signed(b)); end
            CMD_EQ:  begin boo = 1'b1; r = 64'(a == b); end
            CMD_NE:  begin boo = 1'b1; r = 64'(a != b); end
            CMD_AND: r = a & b;
            CMD_XOR: r = a ^ b;
            CMD_OR:  r = a | b;
            default: st = ST_BADCMD;
        endcase
        if (st != ST_OK)
        begin
            r = '0;
            boo = 1'b0;
        end
        res.value = r;
        res.is_bool = boo;
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            result_q.push_back(compute_alu(s_axis_tuser, s_axis_tdata[63:0],
                                           s_axis_tdata[127:64]));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (result_q.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                exp_r = result_q.pop_front();
                if (m_axis_tdata !== exp_r.value)
                    report_mismatch($sformatf("value got %h want %h",
                                              m_axis_tdata, exp_r.value));
                if (m_axis_tuser[0] !== exp_r.is_bool)
                    report_mismatch($sformatf("is_boolean got %b want %b",
                                              m_axis_tuser[0], exp_r.is_bool));
                if (m_axis_tuser[3:1] !== exp_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser[3:1], exp_r.status));
            end
        end
        pending = result_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random ALU transactions with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import sia_pkg::*;

    localparam int LATENCY = WIDTH + 1;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [4:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    int           fail_count;
    int           pending;

    signed_integer_alu_unit uut (.*);

    alu_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return 64'($urandom_range(0, 2));
            4: return 64'(signed'($urandom_range(0, 130)) - 65);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // an opcode outside the defined command set
    function automatic logic [4:0] bad_cmd();
        return 5'($urandom_range(20, 31));
    endfunction

    task automatic send_op(logic [4:0] cmd, logic [63:0] a, logic [63:0] b);
        int g;
        g = gap_len();
        repeat (g)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [4:0] cmd;
        logic [63:0] a, b;
        cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                           : 5'($urandom_range(0, 19));
        a = rand_word();
        b = rand_word();
        if (cmd == CMD_POW && $urandom_range(0, 1))
        begin
            a = 64'(signed'($urandom_range(0, 20)) - 10);
            b = 64'($urandom_range(0, 70));
        end
        if ((cmd == CMD_SHL || cmd == CMD_SHR) && $urandom_range(0, 3) != 0)
            b = 64'($urandom_range(0, 63));
        send_op(cmd, a, b);
    endtask

    // receiver stalls at random
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = gap_len();
            m_axis_tready <= 1'b0;
            repeat (g) @(negedge clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 60) : 1) @(negedge clk);
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed extremes and special cases
        for (int c = 0; c < 20; c++)
            send_op(5'(c), 64'h8000_0000_0000_0000, '1);
        send_op(bad_cmd(), '0, '0);
        send_op(CMD_DIV, 64'd7, '0);
        send_op(CMD_MOD, -64'sd7, 64'd2);
        send_op(CMD_POW, '0, -64'sd3);
        send_op(CMD_POW, '0, '0);
        send_op(CMD_POW, 64'd3, 64'd40);
        send_op(CMD_SHR, -64'sd9, 64'd64);
        send_op(CMD_SHL, '1, 64'd63);

        for (int n = 0; n < 1000; n++)
        begin
            send_random();
            if (n == 500)
            begin
                // drain every outstanding result before going on
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("signed_integer_alu_unit verification clean");
        else
            $display("signed_integer_alu_unit verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("signed_integer_alu_unit verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/sia_pkg.sv
src/sia_mul.sv
src/sia_pow.sv
src/sia_div.sv
src/signed_integer_alu_unit.sv
src/sia_checker.sv
tb/alu_checker.sv
tb/tb_top.sv
